FILE: design/sfd_pkg.sv
// Shared types and constants for the serial frame deframer.
// No dependencies; used by sensor_serial_frame_deframer_top and its testbench.
`timescale 1ns / 1ps

package sfd_pkg;

  // Default frame buffer depth in bytes.
  localparam int MAX_FRAME_DEF = 64;

  // Field widths.
  localparam int BYTE_W      = 8;
  localparam int TOTAL_W     = 7;
  localparam int INDEX_W     = 6;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 8;

  // Smallest legal frame total: head, type, length and end.
  localparam int MIN_TOTAL = 4;

  // Byte position at which the type and length pair is complete.
  localparam int KIND_CHECK_COUNT = 3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_HEAD_BYTE     = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_END_BYTE      = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_TYPE    = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_LENGTH  = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SECOND_TYPE   = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_SECOND_LENGTH = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_TOTAL   = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_SECOND_TOTAL  = 4'd7;

  // Reset values of the configuration registers.
  localparam logic [BYTE_W-1:0]  HEAD_BYTE_RST     = 8'd252;
  localparam logic [BYTE_W-1:0]  END_BYTE_RST      = 8'd253;
  localparam logic [BYTE_W-1:0]  FIRST_TYPE_RST    = 8'd64;
  localparam logic [BYTE_W-1:0]  FIRST_LENGTH_RST  = 8'd56;
  localparam logic [BYTE_W-1:0]  SECOND_TYPE_RST   = 8'd65;
  localparam logic [BYTE_W-1:0]  SECOND_LENGTH_RST = 8'd48;
  localparam logic [TOTAL_W-1:0] FIRST_TOTAL_RST   = 7'd64;
  localparam logic [TOTAL_W-1:0] SECOND_TOTAL_RST  = 7'd56;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_FIRST,
    KIND_SECOND
  } kind_t;

  typedef enum logic {
    ST_COLLECT,
    ST_DRAIN
  } state_t;

endpackage

FILE: design/sfd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module sfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/sensor_serial_frame_deframer_top.sv
// Serial frame deframer top level: collects bytes into a frame buffer and replays good frames.
// Depends on sfd_pkg and sfd_ram.
// The byte that completes a good frame starts the replay: the state register turns to drain,
// then the buffer read and the output register follow. Throughput: one byte per cycle while
// collecting, then one stored byte per cycle from the single read port while not stalled.
// Reset (synchronous, active high) returns to collecting with no frame open and default registers.
`timescale 1ns / 1ps

module sensor_serial_frame_deframer_top #(
  parameter int MAX_FRAME = sfd_pkg::MAX_FRAME_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // Received byte channel.
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [sfd_pkg::BYTE_W-1:0]     rx_byte,
  // Frame byte channel.
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           frame_kind,
  output logic [sfd_pkg::INDEX_W-1:0]    byte_index,
  output logic [sfd_pkg::BYTE_W-1:0]     frame_byte,
  output logic                           last_byte,
  // Configuration write channel.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sfd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sfd_pkg::CFG_DATA_W-1:0] cfg_data
);

  import sfd_pkg::*;

  // Address width of the frame buffer, and a count that can hold MAX_FRAME itself.
  localparam int AW    = $clog2(MAX_FRAME);
  localparam int CNT_W = $clog2(MAX_FRAME + 1);
  // Common width for comparing 7-bit totals against counts and MAX_FRAME.
  localparam int CMP_W = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;
  // Width wide enough to take the low six bits of a buffer position.
  localparam int IW    = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  // Configuration registers.
  logic [BYTE_W-1:0]  head_byte;
  logic [BYTE_W-1:0]  end_byte;
  logic [BYTE_W-1:0]  first_type_byte;
  logic [BYTE_W-1:0]  first_length_byte;
  logic [BYTE_W-1:0]  second_type_byte;
  logic [BYTE_W-1:0]  second_length_byte;
  logic [TOTAL_W-1:0] first_frame_total;
  logic [TOTAL_W-1:0] second_frame_total;

  // Frame tracking state.
  state_t            state;
  state_t            state_next;
  logic [BYTE_W-1:0] previous_byte;
  logic [CNT_W-1:0]  byte_count;
  logic [CNT_W-1:0]  byte_count_next;
  kind_t             kind_found;
  kind_t             kind_found_next;
  logic              start_drain;

  // Readout state: the kind and length of the frame being replayed.
  logic              drain_kind;
  logic [CNT_W-1:0]  drain_total;
  logic [CNT_W-1:0]  drain_total_next;
  logic [CNT_W-1:0]  rd_addr;
  logic [CNT_W-1:0]  pend_addr;
  logic              rd_pending;
  logic              rd_issue;
  logic              out_load;
  logic              drain_done;

  // Frame buffer ports.
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [BYTE_W-1:0] rd_data;

  logic              in_fire;
  logic              cfg_fire;

  // Working values of the byte step.
  logic [CNT_W-1:0]   cnt_inc;
  kind_t              kind_eff;
  logic [TOTAL_W-1:0] total_sel;
  logic [CMP_W-1:0]   total_cmp;
  logic [CMP_W-1:0]   cnt_cmp;
  logic               total_ok;
  logic [IW-1:0]      idx_wide;

  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // Configuration writes. Indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_byte          <= HEAD_BYTE_RST;
      end_byte           <= END_BYTE_RST;
      first_type_byte    <= FIRST_TYPE_RST;
      first_length_byte  <= FIRST_LENGTH_RST;
      second_type_byte   <= SECOND_TYPE_RST;
      second_length_byte <= SECOND_LENGTH_RST;
      first_frame_total  <= FIRST_TOTAL_RST;
      second_frame_total <= SECOND_TOTAL_RST;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        CFG_HEAD_BYTE:     head_byte          <= cfg_data;
        CFG_END_BYTE:      end_byte           <= cfg_data;
        CFG_FIRST_TYPE:    first_type_byte    <= cfg_data;
        CFG_FIRST_LENGTH:  first_length_byte  <= cfg_data;
        CFG_SECOND_TYPE:   second_type_byte   <= cfg_data;
        CFG_SECOND_LENGTH: second_length_byte <= cfg_data;
        CFG_FIRST_TOTAL:   first_frame_total  <= cfg_data[TOTAL_W-1:0];
        CFG_SECOND_TOTAL:  second_frame_total <= cfg_data[TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Byte step. Every accepted byte is written to the buffer: at position zero while
  // no frame is open, so the head lands there, and at the running count once a frame
  // is open. The type byte is the byte held in previous_byte when the length byte
  // arrives, and the final byte of a frame is the byte arriving, so the buffer never
  // has to be read during collection.
  always_comb begin
    byte_count_next  = byte_count;
    kind_found_next  = kind_found;
    start_drain      = 1'b0;
    wr_en            = in_fire;
    wr_addr          = byte_count[AW-1:0];
    cnt_inc          = byte_count + 1'b1;
    kind_eff         = kind_found;
    total_sel        = first_frame_total;
    total_cmp        = '0;
    cnt_cmp          = '0;
    total_ok         = 1'b0;
    drain_total_next = drain_total;

    if (in_fire) begin
      if (byte_count == '0) begin
        wr_addr = '0;
        if (previous_byte == end_byte && rx_byte == head_byte) begin
          byte_count_next = CNT_W'(1);
        end
      end else begin
        // Once the type and length pair is in, pick the kind; the first kind wins a tie.
        if (cnt_inc == CNT_W'(KIND_CHECK_COUNT) && kind_found == KIND_NONE) begin
          priority if (previous_byte == first_type_byte && rx_byte == first_length_byte) begin
            kind_eff = KIND_FIRST;
          end else if (previous_byte == second_type_byte
                       && rx_byte == second_length_byte) begin
            kind_eff = KIND_SECOND;
          end else begin
            kind_eff = KIND_NONE;
          end
        end

        total_sel = (kind_eff == KIND_SECOND) ? second_frame_total : first_frame_total;
        total_cmp = CMP_W'(total_sel);
        cnt_cmp   = CMP_W'(cnt_inc);
        total_ok  = (total_cmp >= CMP_W'(MIN_TOTAL)) && (total_cmp <= CMP_W'(MAX_FRAME));

        if (kind_eff == KIND_NONE) begin
          // Unknown type and length pair abandons the frame.
          if (cnt_inc >= CNT_W'(KIND_CHECK_COUNT)) begin
            byte_count_next = '0;
            kind_found_next = KIND_NONE;
          end else begin
            byte_count_next = cnt_inc;
          end
        end else if (!total_ok || cnt_cmp > total_cmp) begin
          byte_count_next = '0;
          kind_found_next = KIND_NONE;
        end else if (cnt_cmp == total_cmp) begin
          // Frame complete: replay it only when it closes on the end byte.
          byte_count_next  = '0;
          kind_found_next  = KIND_NONE;
          start_drain      = (rx_byte == end_byte);
          drain_total_next = CNT_W'(total_cmp);
        end else begin
          byte_count_next = cnt_inc;
          kind_found_next = kind_eff;
        end
      end
    end
  end

  // Readout handshake with the buffer. A read is issued only when its data will have a
  // place to go: the registered read data holds while the output register is stalled.
  assign out_load   = rd_pending && (!out_valid || !out_stall);
  assign rd_issue   = (state == ST_DRAIN) && (rd_addr != drain_total)
                      && (!rd_pending || out_load);
  assign drain_done = (state == ST_DRAIN) && (rd_addr == drain_total)
                      && (!rd_pending || out_load);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_COLLECT: if (start_drain) state_next = ST_DRAIN;
      ST_DRAIN:   if (drain_done) state_next = ST_COLLECT;
      default:    state_next = ST_COLLECT;
    endcase
  end

  // Outputs of the state machine: no byte is taken while a frame is replayed.
  always_comb begin
    unique case (state)
      ST_COLLECT: in_stall = 1'b0;
      ST_DRAIN:   in_stall = 1'b1;
      default:    in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_COLLECT;
      previous_byte <= '0;
      byte_count    <= '0;
      kind_found    <= KIND_NONE;
      rd_pending    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state      <= state_next;
      byte_count <= byte_count_next;
      kind_found <= kind_found_next;
      if (in_fire) begin
        previous_byte <= rx_byte;
      end
      if (rd_issue) begin
        rd_pending <= 1'b1;
      end else if (out_load) begin
        rd_pending <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers of the readout.
  always_ff @(posedge clk) begin
    if (start_drain) begin
      drain_kind  <= (kind_eff == KIND_SECOND);
      drain_total <= drain_total_next;
      rd_addr     <= '0;
    end else if (rd_issue) begin
      rd_addr <= rd_addr + 1'b1;
    end
    if (rd_issue) begin
      pend_addr <= rd_addr;
    end
  end

  assign idx_wide = IW'(pend_addr);

  always_ff @(posedge clk) begin
    if (out_load) begin
      frame_kind <= drain_kind;
      byte_index <= idx_wide[INDEX_W-1:0];
      frame_byte <= rd_data;
      last_byte  <= (pend_addr == drain_total - 1'b1);
    end
  end

  sfd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_FRAME)
  ) u_frame_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (rx_byte),
    .re    (rd_issue),
    .raddr (rd_addr[AW-1:0]),
    .rdata (rd_data)
  );

endmodule

FILE: tb/sv/sensor_serial_frame_deframer_top_tb.sv
// Self-checking testbench for the serial frame deframer: directed frame cases, then random
// frame streams under several register settings, with random idling on both channels.
// Depends on sfd_pkg and sensor_serial_frame_deframer_top.
`timescale 1ns / 1ps

module sensor_serial_frame_deframer_top_tb;
  import sfd_pkg::*;

  localparam int PERIOD = 12;
  // Cycles allowed after the last expected item before the block is taken to be idle.
  localparam int SETTLE_CYCLES = 8;
  // Cycles without any accepted item before the run is declared hung.
  localparam int STUCK_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 300;
  localparam int RANDOM_PHASES = 6;
  // Register indexes past the end of the list; the block must ignore writes to them.
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_LOW = 4'd8;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_TOP = 4'd15;

  // One emitted frame byte as the block should present it.
  typedef struct packed {
    logic               kind;
    logic [INDEX_W-1:0] index;
    logic [BYTE_W-1:0]  data;
    logic               last;
  } frame_byte_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [BYTE_W-1:0]      rx_byte = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   frame_kind;
  logic [INDEX_W-1:0]     byte_index;
  logic [BYTE_W-1:0]      frame_byte;
  logic                   last_byte;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Shadow copies of the configuration registers, at their reset values.
  logic [BYTE_W-1:0]  head_val    = HEAD_BYTE_RST;
  logic [BYTE_W-1:0]  end_val     = END_BYTE_RST;
  logic [BYTE_W-1:0]  first_type  = FIRST_TYPE_RST;
  logic [BYTE_W-1:0]  first_len   = FIRST_LENGTH_RST;
  logic [BYTE_W-1:0]  second_type = SECOND_TYPE_RST;
  logic [BYTE_W-1:0]  second_len  = SECOND_LENGTH_RST;
  logic [TOTAL_W-1:0] first_total  = FIRST_TOTAL_RST;
  logic [TOTAL_W-1:0] second_total = SECOND_TOTAL_RST;

  // Frame tracking state of the predictor.
  logic [BYTE_W-1:0] last_rx = '0;
  int                fill_count = 0;
  kind_t             open_kind = KIND_NONE;
  logic [BYTE_W-1:0] frame_buf [MAX_FRAME_DEF];

  frame_byte_t pending_frame_bytes[$];
  int          errors = 0;
  int          rx_sent = 0;
  int          quiet_cycles = 0;
  int          stall_left = 0;
  bit          idle_en = 1'b1;

  sensor_serial_frame_deframer_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .frame_kind(frame_kind),
    .byte_index(byte_index),
    .frame_byte(frame_byte),
    .last_byte (last_byte),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(PERIOD / 2) clk = ~clk;

  // Follows one received byte through the framing rules and queues the frame bytes that it
  // releases. A frame opens on a head byte right after an end byte; bytes 1 and 2 pick the
  // kind, and a kind whose total lies outside 4..64 abandons the frame at once. When the count
  // reaches the total, the frame is replayed only if its final byte is the end byte.
  function automatic void deframe_rx_byte(input logic [BYTE_W-1:0] rx);
    int          total;
    int          i;
    frame_byte_t fb;
    if (fill_count == 0) begin
      frame_buf[0] = rx;
      if (last_rx == end_val && rx == head_val) fill_count = 1;
      last_rx = rx;
      return;
    end
    if (fill_count < MAX_FRAME_DEF) frame_buf[fill_count] = rx;
    fill_count++;
    last_rx = rx;
    if (fill_count == KIND_CHECK_COUNT && open_kind == KIND_NONE) begin
      // The first kind wins when both pairs match.
      if (frame_buf[1] == first_type && frame_buf[2] == first_len) begin
        open_kind = KIND_FIRST;
      end else if (frame_buf[1] == second_type && frame_buf[2] == second_len) begin
        open_kind = KIND_SECOND;
      end else begin
        fill_count = 0;
        return;
      end
    end
    if (open_kind == KIND_NONE) return;
    total = (open_kind == KIND_FIRST) ? int'(first_total) : int'(second_total);
    if (total < MIN_TOTAL || total > MAX_FRAME_DEF || fill_count > total) begin
      fill_count = 0;
      open_kind = KIND_NONE;
      return;
    end
    if (fill_count != total) return;
    if (frame_buf[total-1] == end_val) begin
      for (i = 0; i < total; i++) begin
        fb.kind  = (open_kind == KIND_SECOND);
        fb.index = i[INDEX_W-1:0];
        fb.data  = frame_buf[i];
        fb.last  = (i == total - 1);
        pending_frame_bytes.push_back(fb);
      end
    end
    fill_count = 0;
    open_kind = KIND_NONE;
  endfunction

  // Sends one received byte, sometimes after a random gap, and predicts its effect once the
  // block has taken it. Valid is left high so that back-to-back items need no extra edge.
  task automatic send_rx(input logic [BYTE_W-1:0] b);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    deframe_rx_byte(b);
    rx_sent++;
  endtask

  // Writes one register and mirrors it in the shadow copy. The caller lowers cfg_valid after
  // its last write, so consecutive writes go out on consecutive edges.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_HEAD_BYTE:     head_val = data;
      CFG_END_BYTE:      end_val = data;
      CFG_FIRST_TYPE:    first_type = data;
      CFG_FIRST_LENGTH:  first_len = data;
      CFG_SECOND_TYPE:   second_type = data;
      CFG_SECOND_LENGTH: second_len = data;
      CFG_FIRST_TOTAL:   first_total = data[TOTAL_W-1:0];
      CFG_SECOND_TOTAL:  second_total = data[TOTAL_W-1:0];
      default: ;
    endcase
  endtask

  // Stops sending, waits for every predicted frame byte, then gives the block time to finish
  // any frame that is being dropped without output.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_frame_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // With reset registers, opens a first kind frame, then shortens its total while the frame
  // is open. The new total takes effect from the next byte, so the frame closes at five bytes.
  task automatic test_reset_values_mid_frame();
    send_rx(END_BYTE_RST);
    send_rx(HEAD_BYTE_RST);
    send_rx(FIRST_TYPE_RST);
    send_rx(FIRST_LENGTH_RST);
    settle();
    write_reg(CFG_FIRST_TOTAL, 8'd5);
    cfg_valid <= 1'b0;
    send_rx(8'hA5);
    send_rx(END_BYTE_RST);
  endtask

  // Loads every register with extreme values, including a total with its unused top bit set,
  // plus two writes to indexes outside the list. A minimum length frame must then pass.
  task automatic test_extreme_registers();
    settle();
    write_reg(CFG_HEAD_BYTE, 8'h00);
    write_reg(CFG_END_BYTE, 8'hFF);
    write_reg(CFG_FIRST_TYPE, 8'hFF);
    write_reg(CFG_FIRST_LENGTH, 8'h00);
    write_reg(CFG_SECOND_TYPE, 8'h00);
    write_reg(CFG_SECOND_LENGTH, 8'hFF);
    write_reg(CFG_FIRST_TOTAL, 8'h84);
    write_reg(CFG_SECOND_TOTAL, 8'h40);
    write_reg(CFG_UNUSED_LOW, 8'h5A);
    write_reg(CFG_UNUSED_TOP, 8'hA5);
    cfg_valid <= 1'b0;
    send_rx(8'hFF);
    send_rx(8'h00);
    send_rx(8'hFF);
    send_rx(8'h00);
    send_rx(8'hFF);
  endtask

  // A complete frame whose final byte is not the end byte is dropped with no output.
  task automatic test_bad_end_byte();
    send_rx(8'h00);
    send_rx(8'hFF);
    send_rx(8'h00);
    send_rx(8'h07);
  endtask

  // A type and length pair that matches neither kind abandons the frame.
  task automatic test_unknown_kind();
    send_rx(8'hFF);
    send_rx(8'h00);
    send_rx(8'hFF);
    send_rx(8'hFF);
  endtask

  // Both kinds get the same type and length pair; the first kind must win.
  task automatic test_both_kinds_match();
    settle();
    write_reg(CFG_SECOND_TYPE, 8'hFF);
    write_reg(CFG_SECOND_LENGTH, 8'h00);
    write_reg(CFG_SECOND_TOTAL, 8'h85);
    cfg_valid <= 1'b0;
    send_rx(8'h00);
    send_rx(8'hFF);
    send_rx(8'h00);
    send_rx(8'hFF);
  endtask

  // Totals of zero and of 127 abandon a selected frame. In between, a second kind frame
  // carries the head byte as ordinary data and must come out whole.
  task automatic test_totals_out_of_range();
    settle();
    write_reg(CFG_FIRST_TOTAL, 8'h80);
    cfg_valid <= 1'b0;
    send_rx(8'h00);
    send_rx(8'hFF);
    send_rx(8'h00);
    settle();
    write_reg(CFG_FIRST_TYPE, 8'h11);
    cfg_valid <= 1'b0;
    send_rx(8'hFF);
    send_rx(8'h00);
    send_rx(8'hFF);
    send_rx(8'h00);
    send_rx(8'h00);
    send_rx(8'hFF);
    settle();
    write_reg(CFG_SECOND_TOTAL, 8'h7F);
    cfg_valid <= 1'b0;
    send_rx(8'h00);
    send_rx(8'hFF);
    send_rx(8'h00);
  endtask

  // Random register settings, each followed by a stream of mostly well-formed frames with
  // random payload. The rest are frames with a spoiled end or type byte, truncated frames
  // and short runs of noise. One phase uses the largest total and one an illegal total;
  // idling is switched off in one middle phase and in the last one.
  task automatic test_random_frames();
    int                 phase;
    int                 stop_at;
    int                 total;
    int                 stop;
    int                 i;
    int                 flaw;
    logic               use_first;
    logic               pad;
    logic [TOTAL_W-1:0] t1;
    logic [TOTAL_W-1:0] t2;
    logic [BYTE_W-1:0]  spoil;
    logic [BYTE_W-1:0]  type_b;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      idle_en = (phase != 2) && (phase != RANDOM_PHASES - 1);
      settle();
      t1 = TOTAL_W'($urandom_range(MIN_TOTAL, 12));
      t2 = TOTAL_W'($urandom_range(MIN_TOTAL, 12));
      if (phase == 3) t1 = TOTAL_W'(MAX_FRAME_DEF);
      if (phase == 4) begin
        t2 = ($urandom_range(0, 1) != 0) ? TOTAL_W'($urandom_range(0, 3))
                                          : TOTAL_W'($urandom_range(65, 127));
      end
      write_reg(CFG_HEAD_BYTE, CFG_DATA_W'($urandom_range(0, 255)));
      write_reg(CFG_END_BYTE, CFG_DATA_W'($urandom_range(0, 255)));
      write_reg(CFG_FIRST_TYPE, CFG_DATA_W'($urandom_range(0, 255)));
      write_reg(CFG_FIRST_LENGTH, CFG_DATA_W'($urandom_range(0, 255)));
      write_reg(CFG_SECOND_TYPE, CFG_DATA_W'($urandom_range(0, 255)));
      write_reg(CFG_SECOND_LENGTH, CFG_DATA_W'($urandom_range(0, 255)));
      pad = ($urandom_range(0, 1) != 0);
      write_reg(CFG_FIRST_TOTAL, {pad, t1});
      pad = ($urandom_range(0, 1) != 0);
      write_reg(CFG_SECOND_TOTAL, {pad, t2});
      cfg_valid <= 1'b0;
      stop_at = rx_sent + RANDOM_ITEMS / RANDOM_PHASES;
      while (rx_sent < stop_at) begin
        use_first = ($urandom_range(0, 1) != 0);
        flaw = $urandom_range(0, 9);
        spoil = BYTE_W'($urandom_range(1, 255));
        if (flaw == 9) begin
          // Noise between frames.
          repeat ($urandom_range(1, 4)) send_rx(BYTE_W'($urandom_range(0, 255)));
        end else begin
          total = use_first ? int'(first_total) : int'(second_total);
          if (total < MIN_TOTAL || total > MAX_FRAME_DEF) total = $urandom_range(MIN_TOTAL, 8);
          type_b = use_first ? first_type : second_type;
          if (flaw == 7) type_b = type_b ^ spoil;
          // A frame only opens right after an end byte.
          if (fill_count == 0 && last_rx != end_val) send_rx(end_val);
          send_rx(head_val);
          send_rx(type_b);
          send_rx(use_first ? first_len : second_len);
          stop = (flaw == 8) ? $urandom_range(3, total - 1) : total - 1;
          for (i = 3; i < stop; i++) begin
            if (i == 3 && $urandom_range(0, 3) == 0) send_rx(head_val);
            else send_rx(BYTE_W'($urandom_range(0, 255)));
          end
          if (flaw != 8) send_rx(flaw == 6 ? end_val ^ spoil : end_val);
        end
      end
    end
  endtask

  // Result checker and receiver stall. Each frame byte taken from the block is matched against
  // the oldest prediction. Stall comes in random bursts while idling is on.
  always @(posedge clk) begin
    frame_byte_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_frame_bytes.size() == 0) begin
        $error("unexpected frame byte: index %0d data 0x%02h", byte_index, frame_byte);
        errors++;
      end else begin
        want = pending_frame_bytes.pop_front();
        if (frame_kind !== want.kind) begin
          $error("frame_kind: expected %0d, got %0d", want.kind, frame_kind);
          errors++;
        end
        if (byte_index !== want.index) begin
          $error("byte_index: expected %0d, got %0d", want.index, byte_index);
          errors++;
        end
        if (frame_byte !== want.data) begin
          $error("frame_byte: expected 0x%02h, got 0x%02h", want.data, frame_byte);
          errors++;
        end
        if (last_byte !== want.last) begin
          $error("last_byte: expected %0d, got %0d", want.last, last_byte);
          errors++;
        end
      end
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 15);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: a long stretch with no item accepted on any channel means the block is hung.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STUCK_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Reset once, run every test in turn, drain, and report.
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_values_mid_frame();
    test_extreme_registers();
    test_bad_end_byte();
    test_unknown_kind();
    test_both_kinds_match();
    test_totals_out_of_range();
    test_random_frames();
    settle();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
